### hw/rtl/ffha_pkg.sv
// Shared constants, types and helpers for the first-fit heap allocator.
package ffha_pkg;

   localparam int HEAP_BYTES  = 4096;
   localparam int ALIGN_BYTES = 8;
   localparam int HEAD_BYTES  = 16;
   localparam int BHDR_BYTES  = 8;
   localparam int SLOT_COUNT  = HEAP_BYTES / ALIGN_BYTES;
   localparam int SLOT_W      = $clog2(SLOT_COUNT);
   localparam int POS_W       = $clog2(HEAP_BYTES) + 1;
   localparam int SUM_W       = POS_W + 1;
   localparam int HDR_W       = 13;
   localparam int OFF_W       = 12;
   localparam int SIZE_W      = 12;
   localparam int CNT_W       = 10;
   localparam int LIMIT_W     = 13;
   localparam int KIND_W      = 2;
   localparam int OFF_MAX     = (1 << OFF_W) - 1;
   localparam int LIMIT_RESET = 4096;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC   = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_RESIZE  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_OLD,
      ST_WALK,
      ST_APPEND,
      ST_FREE_OLD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             valid;
      logic [OFF_W-1:0] offset;
      logic             failed;
   } rsp_ctl_type;

   // Block size with header, rounded up to the alignment.
   function automatic logic [HDR_W-1:0] block_bytes(input logic [SIZE_W-1:0] req);
      logic [HDR_W-1:0] sum;
      sum = HDR_W'(req) + HDR_W'(BHDR_BYTES + ALIGN_BYTES - 1);
      return {sum[HDR_W-1:3], 3'b000};
   endfunction

endpackage

### hw/rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: config register, header RAM, response stage.
// Flow: a release reads the old header and clears its busy bit; an alloc walks the header list
//   from the head, one header a cycle, and appends a block after the last when none fits; a
//   growing resize adds the old-header read and the free of the old block. One request in
//   flight; the next is taken once the result moves to the response register.
// Reset: synchronous; heap_limit to 4096; a pass clears all 512 header slots with req_ready low.
module first_fit_heap_allocator import ffha_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [OFF_W-1:0]   req_payload_offset,
   input  logic [SIZE_W-1:0]  req_request_size,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [OFF_W-1:0]   rsp_result_offset,
   output logic               rsp_failed,
   input  logic               csr_write_enable,
   input  logic [LIMIT_W-1:0] csr_write_data
);

   logic [LIMIT_W-1:0] heap_limit_ff, heap_limit_in;
   logic [LIMIT_W-1:0] eff_limit;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OFF_W-1:0]   rsp_offset_ff, rsp_offset_in;
   logic               rsp_failed_ff, rsp_failed_in;
   logic               rsp_free;
   rsp_ctl_type        done;
   logic               ram_wr_en;
   logic [SLOT_W-1:0]  ram_wr_addr;
   logic [HDR_W-1:0]   ram_wr_data;
   logic [SLOT_W-1:0]  ram_rd_addr;
   logic [HDR_W-1:0]   ram_rd_data;

   // Limit register: a value above the heap size acts as the heap size.
   always_comb begin
      heap_limit_in = csr_write_enable ? csr_write_data : heap_limit_ff;
      eff_limit     = (heap_limit_ff > LIMIT_W'(HEAP_BYTES)) ? LIMIT_W'(HEAP_BYTES)
                                                             : heap_limit_ff;
   end

   // Response stage: the sequencer hands off a result whenever this slot is empty
   // or being drained in the same cycle; while a result waits here, a new result
   // holds the sequencer in its done state, which stalls intake.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_failed_in = rsp_failed_ff;
      if (done.valid && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_offset_in = done.offset;
         rsp_failed_in = done.failed;
      end else if (rsp_ready) begin
         // Drop the entry once the transfer completes.
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_limit_ff <= LIMIT_W'(LIMIT_RESET);
         rsp_valid_ff  <= 1'b0;
      end else begin
         heap_limit_ff <= heap_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_offset_ff <= rsp_offset_in;
      rsp_failed_ff <= rsp_failed_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_offset = rsp_offset_ff;
   assign rsp_failed        = rsp_failed_ff;

   // Block header store: one entry per 8-byte slot of the heap.
   ffha_ram #(
      .WIDTH (HDR_W),
      .DEPTH (SLOT_COUNT)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer: walks the implicit list and performs read-modify-write on headers.
   ffha_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_payload_offset (req_payload_offset),
      .req_request_size   (req_request_size),
      .limit              (eff_limit),
      .rsp_free           (rsp_free),
      .done               (done),
      .ram_wr_en          (ram_wr_en),
      .ram_wr_addr        (ram_wr_addr),
      .ram_wr_data        (ram_wr_data),
      .ram_rd_addr        (ram_rd_addr),
      .ram_rd_data        (ram_rd_data)
   );

endmodule

### hw/rtl/ffha_ram.sv
// Generic simple dual-port RAM with registered read.
module ffha_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ffha_seq.sv
// Request sequencer: header clear pass, list walk, append, release and resize.
module ffha_seq import ffha_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [OFF_W-1:0]   req_payload_offset,
   input  logic [SIZE_W-1:0]  req_request_size,
   input  logic [LIMIT_W-1:0] limit,
   input  logic               rsp_free,
   output rsp_ctl_type        done,
   output logic               ram_wr_en,
   output logic [SLOT_W-1:0]  ram_wr_addr,
   output logic [HDR_W-1:0]   ram_wr_data,
   output logic [SLOT_W-1:0]  ram_rd_addr,
   input  logic [HDR_W-1:0]   ram_rd_data
);

   state_type          state_ff, state_in;
   kind_type           kind_ff, kind_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [HDR_W-1:0]   need_ff, need_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [HDR_W-1:0]   used_ff, used_in;
   logic               grow_ff, grow_in;
   logic [SLOT_W-1:0]  old_slot_ff, old_slot_in;
   logic [HDR_W-1:0]   old_sz_ff, old_sz_in;
   logic [OFF_W-1:0]   res_off_ff, res_off_in;
   logic               res_fail_ff, res_fail_in;
   logic [SLOT_W-1:0]  clr_ff, clr_in;

   logic               is_alloc;
   logic               off_ok;
   logic [SLOT_W-1:0]  old_slot;
   logic [HDR_W-1:0]   hdr_sz;
   logic               hdr_busy;
   logic               grab_over;
   logic               walk_bad;
   logic               walk_hit;
   logic [POS_W-1:0]   pos_next;
   logic               walk_last;
   logic               app_fail;
   logic               old_fits;
   logic [HDR_W-1:0]   used_less_old;
   logic [HDR_W-1:0]   used_less_hdr;
   logic [OFF_W-1:0]   pos_payload;
   state_type          grab_target;
   state_type          grant_target;

   always_comb begin
      is_alloc    = (kind_ff == KIND_ALLOC) || (kind_ff == KIND_RESIZE && off_ff == '0);
      off_ok      = (off_ff[2:0] == 3'b000) && (off_ff >= OFF_W'(HEAD_BYTES + BHDR_BYTES));
      old_slot    = off_ff[OFF_W-1:3] - SLOT_W'(1);
      hdr_sz      = {ram_rd_data[HDR_W-1:1], 1'b0};
      hdr_busy    = ram_rd_data[0];
      grab_over   = ({1'b0, used_ff} + {1'b0, need_ff}) > {1'b0, limit};
      walk_bad    = (pos_ff >= POS_W'(HEAP_BYTES)) || (hdr_sz == '0);
      walk_hit    = !hdr_busy && (hdr_sz >= need_ff);
      pos_next    = pos_ff + POS_W'(hdr_sz);
      walk_last   = (idx_ff + CNT_W'(1)) == count_ff;
      app_fail    = (({1'b0, pos_ff} + SUM_W'(need_ff)) > SUM_W'(limit))
                 || (({1'b0, pos_ff} + SUM_W'(BHDR_BYTES)) > SUM_W'(OFF_MAX));
      old_fits    = need_ff <= hdr_sz;
      used_less_old = (used_ff >= old_sz_ff) ? used_ff - old_sz_ff : '0;
      used_less_hdr = (used_ff >= hdr_sz) ? used_ff - hdr_sz : '0;
      pos_payload = OFF_W'(pos_ff + POS_W'(BHDR_BYTES));
      if (grab_over) begin
         grab_target = ST_DONE;
      end else if (count_ff == '0) begin
         grab_target = ST_APPEND;
      end else begin
         grab_target = ST_WALK;
      end
      grant_target = grow_ff ? ST_FREE_OLD : ST_DONE;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == SLOT_W'(SLOT_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_START;
         end
         ST_START: begin
            priority if (is_alloc) state_in = grab_target;
            else if ((kind_ff == KIND_RELEASE || kind_ff == KIND_RESIZE) && off_ok)
               state_in = ST_OLD;
            else state_in = ST_DONE;
         end
         ST_OLD: begin
            if (kind_ff == KIND_RESIZE && hdr_busy && !old_fits) state_in = grab_target;
            else state_in = ST_DONE;
         end
         ST_WALK: begin
            priority if (walk_bad) state_in = ST_DONE;
            else if (walk_hit) state_in = grant_target;
            else if (walk_last) state_in = ST_APPEND;
            else state_in = ST_WALK;
         end
         ST_APPEND: begin
            state_in = app_fail ? ST_DONE : grant_target;
         end
         ST_FREE_OLD: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      kind_in     = kind_ff;
      off_in      = off_ff;
      need_in     = need_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      used_in     = used_ff;
      grow_in     = grow_ff;
      old_slot_in = old_slot_ff;
      old_sz_in   = old_sz_ff;
      res_off_in  = res_off_ff;
      res_fail_in = res_fail_ff;
      clr_in      = clr_ff;
      req_ready   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = '0;
      ram_rd_addr = '0;
      done.valid  = (state_ff == ST_DONE);
      done.offset = res_off_ff;
      done.failed = res_fail_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            clr_in      = clr_ff + SLOT_W'(1);
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in     = kind_type'(req_kind);
               off_in      = req_payload_offset;
               need_in     = block_bytes(req_request_size);
               grow_in     = 1'b0;
               res_off_in  = '0;
               res_fail_in = 1'b0;
            end
         end
         ST_START: begin
            priority if (is_alloc) begin
               pos_in      = POS_W'(HEAD_BYTES);
               idx_in      = '0;
               ram_rd_addr = SLOT_W'(HEAD_BYTES / ALIGN_BYTES);
               res_fail_in = grab_over;
            end else if (kind_ff == KIND_RELEASE) begin
               ram_rd_addr = old_slot;
               old_slot_in = old_slot;
            end else if (kind_ff == KIND_RESIZE) begin
               ram_rd_addr = old_slot;
               old_slot_in = old_slot;
               res_fail_in = !off_ok;
            end else begin
               res_fail_in = 1'b1;
            end
         end
         ST_OLD: begin
            if (kind_ff == KIND_RELEASE) begin
               if (hdr_busy) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = old_slot_ff;
                  ram_wr_data = hdr_sz;
                  used_in     = used_less_hdr;
               end
            end else if (!hdr_busy) begin
               res_fail_in = 1'b1;
            end else if (old_fits) begin
               res_off_in = off_ff;
            end else begin
               // Grow: look for a new block, keep the old one until granted.
               old_sz_in   = hdr_sz;
               grow_in     = 1'b1;
               pos_in      = POS_W'(HEAD_BYTES);
               idx_in      = '0;
               ram_rd_addr = SLOT_W'(HEAD_BYTES / ALIGN_BYTES);
               res_fail_in = grab_over;
            end
         end
         ST_WALK: begin
            priority if (walk_bad) begin
               res_fail_in = 1'b1;
            end else if (walk_hit) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pos_ff[SLOT_W+2:3];
               ram_wr_data = ram_rd_data | HDR_W'(1);
               used_in     = used_ff + hdr_sz;
               res_off_in  = pos_payload;
            end else begin
               pos_in      = pos_next;
               idx_in      = idx_ff + CNT_W'(1);
               ram_rd_addr = pos_next[SLOT_W+2:3];
            end
         end
         ST_APPEND: begin
            if (app_fail) begin
               res_fail_in = 1'b1;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pos_ff[SLOT_W+2:3];
               ram_wr_data = need_ff | HDR_W'(1);
               count_in    = count_ff + CNT_W'(1);
               used_in     = used_ff + need_ff;
               res_off_in  = pos_payload;
            end
         end
         ST_FREE_OLD: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = old_slot_ff;
            ram_wr_data = old_sz_ff;
            used_in     = used_less_old;
         end
         ST_DONE: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         used_ff  <= HDR_W'(HEAD_BYTES);
         count_ff <= '0;
         pos_ff   <= POS_W'(HEAD_BYTES);
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         used_ff  <= used_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      off_ff      <= off_in;
      need_ff     <= need_in;
      idx_ff      <= idx_in;
      grow_ff     <= grow_in;
      old_slot_ff <= old_slot_in;
      old_sz_ff   <= old_sz_in;
      res_off_ff  <= res_off_in;
      res_fail_ff <= res_fail_in;
   end

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= HDR_W'(HEAP_BYTES))
      else $error("used byte total exceeds heap size");

   a_count_only_on_append: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_APPEND |=> $stable(count_ff))
      else $error("block count changed outside append");

   a_header_nonzero: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && state_ff != ST_CLEAR) |-> ram_wr_data[HDR_W-1:1] != '0)
      else $error("zero-size header written into the list");

   a_pos_aligned: assert property (@(posedge clock) disable iff (reset)
      pos_ff[2:0] == 3'b000)
      else $error("walk position lost alignment");

endmodule
